FILE: hw/rtl/tcce_pkg.sv
// Shared types and constants for the text console cursor engine.
package tcce_pkg;

    // Fixed field widths.
    localparam int CHAR_W   = 8;
    localparam int CELL_W   = 8;
    localparam int PITCH_W  = 16;
    localparam int DEPTH_W  = 6;
    localparam int COLOUR_W = 24;
    localparam int ADDR_W   = 28;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Glyph cells are always eight pixels wide.
    localparam int GLYPH_WIDTH_SHIFT = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLOUR_DEPTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FORE_COLOUR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOUR  = 3'd5;

    // Register reset values.
    localparam logic [CELL_W-1:0]   RESET_COLUMNS      = 8'd80;
    localparam logic [CELL_W-1:0]   RESET_ROWS         = 8'd25;
    localparam logic [PITCH_W-1:0]  RESET_LINE_PITCH   = 16'd2560;
    localparam logic [DEPTH_W-1:0]  RESET_COLOUR_DEPTH = 6'd32;
    localparam logic [COLOUR_W-1:0] RESET_FORE_COLOUR  = 24'hC0C0C0;
    localparam logic [COLOUR_W-1:0] RESET_BACK_COLOUR  = 24'h000000;

    // Control character codes.
    localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'd32;

    // Colour depths with a direct pixel format.
    localparam logic [DEPTH_W-1:0] DEPTH_32 = 6'd32;
    localparam logic [DEPTH_W-1:0] DEPTH_24 = 6'd24;
    localparam logic [DEPTH_W-1:0] DEPTH_16 = 6'd16;
    localparam logic [DEPTH_W-1:0] DEPTH_15 = 6'd15;

    // Palette index base for low colour depths.
    localparam logic [4:0] PALETTE_BASE = 5'h10;

    // Record kinds.
    localparam logic KIND_DRAW   = 1'b0;
    localparam logic KIND_SCROLL = 1'b1;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_SCROLL
    } state_t;

    // Class of the captured character.
    typedef enum logic [1:0] {
        CLS_DRAW,
        CLS_NEWLINE,
        CLS_RETURN,
        CLS_BACKSPACE
    } char_class_t;

    // Datapath operations.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_RETURN,
        OP_BACKSPACE,
        OP_NEWLINE,
        OP_DRAW,
        OP_SCROLL
    } op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_char;
        op_t  op;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        char_class_t char_class;
        logic        at_last_row;
        logic        draw_wraps;
        logic        draw_more;
        logic        slot_free;
    } status_t;

endpackage

FILE: hw/rtl/tcce_ctrl.sv
// Controller state machine that sequences the records of one character.
module tcce_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              char_valid,
    output logic              char_ready,
    input  tcce_pkg::status_t status,
    output tcce_pkg::cmd_t    cmd
);

    tcce_pkg::state_t state_reg;
    tcce_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcce_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next    = state_reg;
        char_ready    = 1'b0;
        cmd.load_char = 1'b0;
        cmd.op        = tcce_pkg::OP_NONE;
        case (state_reg)
            tcce_pkg::ST_IDLE:
            begin
                char_ready = 1'b1;
                if (char_valid)
                begin
                    cmd.load_char = 1'b1;
                    state_next    = tcce_pkg::ST_STEP;
                end
            end
            tcce_pkg::ST_STEP:
            begin
                case (status.char_class)
                    tcce_pkg::CLS_RETURN:
                    begin
                        cmd.op     = tcce_pkg::OP_RETURN;
                        state_next = tcce_pkg::ST_IDLE;
                    end
                    tcce_pkg::CLS_BACKSPACE:
                    begin
                        cmd.op     = tcce_pkg::OP_BACKSPACE;
                        state_next = tcce_pkg::ST_IDLE;
                    end
                    tcce_pkg::CLS_NEWLINE:
                    begin
                        if (!status.at_last_row)
                        begin
                            cmd.op     = tcce_pkg::OP_NEWLINE;
                            state_next = tcce_pkg::ST_IDLE;
                        end
                        else if (status.slot_free)
                        begin
                            cmd.op     = tcce_pkg::OP_SCROLL;
                            state_next = tcce_pkg::ST_IDLE;
                        end
                        else
                        begin
                            state_next = tcce_pkg::ST_SCROLL;
                        end
                    end
                    default:
                    begin
                        // A drawn cell may be followed by a scroll or more tab spaces.
                        if (status.slot_free)
                        begin
                            cmd.op = tcce_pkg::OP_DRAW;
                            if (status.draw_wraps && status.at_last_row)
                            begin
                                state_next = tcce_pkg::ST_SCROLL;
                            end
                            else if (status.draw_more)
                            begin
                                state_next = tcce_pkg::ST_STEP;
                            end
                            else
                            begin
                                state_next = tcce_pkg::ST_IDLE;
                            end
                        end
                    end
                endcase
            end
            tcce_pkg::ST_SCROLL:
            begin
                if (status.slot_free)
                begin
                    cmd.op     = tcce_pkg::OP_SCROLL;
                    state_next = tcce_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tcce_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/tcce_datapath.sv
// Datapath: configuration, cursor, address and colour arithmetic, output register.
module tcce_datapath #(
    parameter int GLYPH_HEIGHT = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [tcce_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tcce_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [tcce_pkg::CHAR_W-1:0]         char_code,
    input  tcce_pkg::cmd_t                      cmd,
    output tcce_pkg::status_t                   status,
    output logic                                rec_valid,
    input  logic                                rec_ready,
    output logic                                record_kind,
    output logic [tcce_pkg::CELL_W-1:0]         cell_column,
    output logic [tcce_pkg::CELL_W-1:0]         cell_row,
    output logic [tcce_pkg::CHAR_W-1:0]         glyph_code,
    output logic [tcce_pkg::ADDR_W-1:0]         cell_address,
    output logic [tcce_pkg::COLOUR_W-1:0]       fore_pixel,
    output logic [tcce_pkg::COLOUR_W-1:0]       back_pixel,
    output logic                                last_record
);

    // Bytes of one text row: line pitch times glyph height.
    localparam int SPAN_W = tcce_pkg::PITCH_W + $clog2(GLYPH_HEIGHT + 1);
    localparam int PROD_W = tcce_pkg::CELL_W + SPAN_W;

    // Convert a 0xRRGGBB colour to the configured depth.
    function automatic logic [tcce_pkg::COLOUR_W-1:0] to_depth(
        input logic [tcce_pkg::COLOUR_W-1:0] colour,
        input logic [tcce_pkg::DEPTH_W-1:0]  depth
    );
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [9:0]  sum;
        logic [19:0] scaled;
        logic [7:0]  mean;
        logic [4:0]  index;
        r = colour[23:16];
        g = colour[15:8];
        b = colour[7:0];
        // Divide by three as a multiply by 683/2048, exact for sums up to 765.
        sum    = 10'(r) + 10'(g) + 10'(b);
        scaled = 20'(sum) * 20'd683;
        mean   = scaled[18:11];
        index  = tcce_pkg::PALETTE_BASE + 5'(mean[7:4]);
        if (depth > tcce_pkg::DEPTH_16)
        begin
            to_depth = colour;
        end
        else if (depth == tcce_pkg::DEPTH_16)
        begin
            to_depth = 24'({r[7:3], g[7:2], b[7:3]});
        end
        else if (depth == tcce_pkg::DEPTH_15)
        begin
            to_depth = 24'({r[7:3], g[7:3], b[7:3]});
        end
        else
        begin
            to_depth = 24'(index);
        end
    endfunction

    // Configuration registers; the line pitch is kept as the bytes of one text row.
    logic [tcce_pkg::CELL_W-1:0]   columns_reg;
    logic [tcce_pkg::CELL_W-1:0]   rows_reg;
    logic [tcce_pkg::DEPTH_W-1:0]  colour_depth_reg;
    logic [tcce_pkg::COLOUR_W-1:0] fore_colour_reg;
    logic [tcce_pkg::COLOUR_W-1:0] back_colour_reg;
    logic [SPAN_W-1:0]             span_reg;

    // Cursor and captured character.
    logic [tcce_pkg::CELL_W-1:0]   col_reg;
    logic [tcce_pkg::CELL_W-1:0]   col_next;
    logic [tcce_pkg::CELL_W-1:0]   row_reg;
    logic [tcce_pkg::CELL_W-1:0]   row_next;
    logic [tcce_pkg::CHAR_W-1:0]   char_reg;

    // Output register.
    logic                          rec_valid_reg;
    logic                          rec_valid_next;
    logic                          kind_reg;
    logic [tcce_pkg::CELL_W-1:0]   out_col_reg;
    logic [tcce_pkg::CELL_W-1:0]   out_row_reg;
    logic [tcce_pkg::CHAR_W-1:0]   glyph_reg;
    logic [tcce_pkg::ADDR_W-1:0]   addr_reg;
    logic [tcce_pkg::COLOUR_W-1:0] fore_reg;
    logic [tcce_pkg::COLOUR_W-1:0] back_reg;
    logic                          last_reg;

    // Combinational values.
    logic [tcce_pkg::CELL_W-1:0]   eff_cols;
    logic [tcce_pkg::CELL_W-1:0]   last_row;
    logic [tcce_pkg::CELL_W:0]     col_plus;
    logic                          wraps;
    logic                          at_last_row;
    logic                          more;
    logic                          is_tab;
    logic                          emit_draw;
    logic                          emit_scroll;
    logic [2:0]                    bpp;
    logic [tcce_pkg::CELL_W-1:0]   addr_row;
    logic [tcce_pkg::CELL_W-1:0]   addr_col;
    logic [PROD_W-1:0]             row_offset;
    logic [tcce_pkg::CELL_W+2:0]   col_bytes;
    logic [tcce_pkg::ADDR_W-1:0]   addr_value;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg      <= tcce_pkg::RESET_COLUMNS;
            rows_reg         <= tcce_pkg::RESET_ROWS;
            span_reg         <= SPAN_W'(tcce_pkg::RESET_LINE_PITCH) * SPAN_W'(GLYPH_HEIGHT);
            colour_depth_reg <= tcce_pkg::RESET_COLOUR_DEPTH;
            fore_colour_reg  <= tcce_pkg::RESET_FORE_COLOUR;
            back_colour_reg  <= tcce_pkg::RESET_BACK_COLOUR;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                tcce_pkg::REG_COLUMNS:      columns_reg      <= cfg_data[tcce_pkg::CELL_W-1:0];
                tcce_pkg::REG_ROWS:         rows_reg         <= cfg_data[tcce_pkg::CELL_W-1:0];
                tcce_pkg::REG_LINE_PITCH:
                begin
                    span_reg <= SPAN_W'(cfg_data[tcce_pkg::PITCH_W-1:0]) * SPAN_W'(GLYPH_HEIGHT);
                end
                tcce_pkg::REG_COLOUR_DEPTH: colour_depth_reg <= cfg_data[tcce_pkg::DEPTH_W-1:0];
                tcce_pkg::REG_FORE_COLOUR:  fore_colour_reg  <= cfg_data;
                tcce_pkg::REG_BACK_COLOUR:  back_colour_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Geometry, with zero treated as one.
    assign eff_cols    = (columns_reg == '0) ? 8'd1 : columns_reg;
    assign last_row    = (rows_reg == '0) ? '0 : rows_reg - 8'd1;
    assign at_last_row = (row_reg >= last_row);
    assign col_plus    = {1'b0, col_reg} + 9'd1;
    assign wraps       = (col_plus >= {1'b0, eff_cols});
    assign is_tab      = (char_reg == tcce_pkg::CHAR_TAB);
    assign more        = is_tab && !wraps && (col_plus[2:0] != 3'd0);
    assign emit_draw   = (cmd.op == tcce_pkg::OP_DRAW);
    assign emit_scroll = (cmd.op == tcce_pkg::OP_SCROLL);

    // Status to the controller.
    always_comb
    begin
        case (char_reg)
            tcce_pkg::CHAR_NEWLINE:   status.char_class = tcce_pkg::CLS_NEWLINE;
            tcce_pkg::CHAR_RETURN:    status.char_class = tcce_pkg::CLS_RETURN;
            tcce_pkg::CHAR_BACKSPACE: status.char_class = tcce_pkg::CLS_BACKSPACE;
            default:                  status.char_class = tcce_pkg::CLS_DRAW;
        endcase
        status.at_last_row = at_last_row;
        status.draw_wraps  = wraps;
        status.draw_more   = more;
        status.slot_free   = !rec_valid_reg || rec_ready;
    end

    // Bytes per pixel.
    always_comb
    begin
        case (colour_depth_reg)
            tcce_pkg::DEPTH_32: bpp = 3'd4;
            tcce_pkg::DEPTH_24: bpp = 3'd3;
            tcce_pkg::DEPTH_16: bpp = 3'd2;
            tcce_pkg::DEPTH_15: bpp = 3'd2;
            default:            bpp = 3'd1;
        endcase
    end

    // Cell address: row times row span plus column times cell width in bytes.
    assign addr_row   = emit_scroll ? last_row : row_reg;
    assign addr_col   = emit_scroll ? '0 : col_reg;
    assign row_offset = PROD_W'(addr_row) * PROD_W'(span_reg);
    assign col_bytes  = 11'(addr_col) * 11'(bpp);
    assign addr_value = tcce_pkg::ADDR_W'(row_offset)
                      + (tcce_pkg::ADDR_W'(col_bytes) << tcce_pkg::GLYPH_WIDTH_SHIFT);

    // Cursor update for each operation.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        case (cmd.op)
            tcce_pkg::OP_RETURN:
            begin
                col_next = '0;
            end
            tcce_pkg::OP_BACKSPACE:
            begin
                if (col_reg != '0)
                begin
                    col_next = col_reg - 8'd1;
                end
                else
                begin
                    col_next = eff_cols - 8'd1;
                    if (row_reg != '0)
                    begin
                        row_next = row_reg - 8'd1;
                    end
                end
            end
            tcce_pkg::OP_NEWLINE:
            begin
                col_next = '0;
                row_next = row_reg + 8'd1;
            end
            tcce_pkg::OP_DRAW:
            begin
                if (wraps)
                begin
                    col_next = '0;
                    if (!at_last_row)
                    begin
                        row_next = row_reg + 8'd1;
                    end
                end
                else
                begin
                    col_next = col_plus[tcce_pkg::CELL_W-1:0];
                end
            end
            tcce_pkg::OP_SCROLL:
            begin
                col_next = '0;
                row_next = last_row;
            end
            default:
            begin
            end
        endcase
    end

    // Output valid: set by an emitted record, cleared when the record is taken.
    always_comb
    begin
        if (emit_draw || emit_scroll)
        begin
            rec_valid_next = 1'b1;
        end
        else if (rec_ready)
        begin
            rec_valid_next = 1'b0;
        end
        else
        begin
            rec_valid_next = rec_valid_reg;
        end
    end

    // Cursor and output valid state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            rec_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            rec_valid_reg <= rec_valid_next;
        end
    end

    // Captured character.
    always_ff @(posedge clk)
    begin
        if (cmd.load_char)
        begin
            char_reg <= char_code;
        end
    end

    // Record payload.
    always_ff @(posedge clk)
    begin
        if (emit_draw)
        begin
            kind_reg    <= tcce_pkg::KIND_DRAW;
            out_col_reg <= col_reg;
            out_row_reg <= row_reg;
            glyph_reg   <= is_tab ? tcce_pkg::CHAR_SPACE : char_reg;
            addr_reg    <= addr_value;
            fore_reg    <= to_depth(fore_colour_reg, colour_depth_reg);
            back_reg    <= to_depth(back_colour_reg, colour_depth_reg);
            last_reg    <= !(wraps && at_last_row) && !more;
        end
        else if (emit_scroll)
        begin
            kind_reg    <= tcce_pkg::KIND_SCROLL;
            out_col_reg <= '0;
            out_row_reg <= last_row;
            glyph_reg   <= '0;
            addr_reg    <= addr_value;
            fore_reg    <= '0;
            back_reg    <= '0;
            last_reg    <= 1'b1;
        end
    end

    assign rec_valid    = rec_valid_reg;
    assign record_kind  = kind_reg;
    assign cell_column  = out_col_reg;
    assign cell_row     = out_row_reg;
    assign glyph_code   = glyph_reg;
    assign cell_address = addr_reg;
    assign fore_pixel   = fore_reg;
    assign back_pixel   = back_reg;
    assign last_record  = last_reg;

endmodule

FILE: hw/rtl/text_console_cursor_engine.sv
// Top level of the text console cursor engine: controller and datapath.
//
// One character is taken per transaction on the char channel and turned into draw and
// scroll records on the rec channel. A printable character is accepted in the idle
// state and its draw record is computed and registered in the step state; carriage
// return, backspace and newline are likewise handled in the step state. A tab draws
// one space per step up to the next tab stop or the row end, and a scroll after a wrap
// at the bottom row is emitted from the scroll state. Each record waits for the single
// output register, which holds it until taken; a stalled rec_ready holds the engine
// until it frees. The cell address takes the row times the row span (line_pitch times
// GLYPH_HEIGHT, from the configuration) plus the column's byte offset. Register
// writes take effect at once and are meant to be made while the engine is idle.
module text_console_cursor_engine #(
    parameter int GLYPH_HEIGHT = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [tcce_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tcce_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             char_valid,
    output logic                             char_ready,
    input  logic [tcce_pkg::CHAR_W-1:0]      char_code,
    output logic                             rec_valid,
    input  logic                             rec_ready,
    output logic                             record_kind,
    output logic [tcce_pkg::CELL_W-1:0]      cell_column,
    output logic [tcce_pkg::CELL_W-1:0]      cell_row,
    output logic [tcce_pkg::CHAR_W-1:0]      glyph_code,
    output logic [tcce_pkg::ADDR_W-1:0]      cell_address,
    output logic [tcce_pkg::COLOUR_W-1:0]    fore_pixel,
    output logic [tcce_pkg::COLOUR_W-1:0]    back_pixel,
    output logic                             last_record
);

    tcce_pkg::cmd_t    cmd;
    tcce_pkg::status_t status;

    // Sequencing of records for one character.
    tcce_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .status     (status),
        .cmd        (cmd)
    );

    // Cursor, arithmetic and output register.
    tcce_datapath #(
        .GLYPH_HEIGHT (GLYPH_HEIGHT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .char_code    (char_code),
        .cmd          (cmd),
        .status       (status),
        .rec_valid    (rec_valid),
        .rec_ready    (rec_ready),
        .record_kind  (record_kind),
        .cell_column  (cell_column),
        .cell_row     (cell_row),
        .glyph_code   (glyph_code),
        .cell_address (cell_address),
        .fore_pixel   (fore_pixel),
        .back_pixel   (back_pixel),
        .last_record  (last_record)
    );

    // A scroll record always ends its character and carries no colour.
    assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && (record_kind == tcce_pkg::KIND_SCROLL)
        |-> last_record && (cell_column == '0) && (fore_pixel == '0)
            && (back_pixel == '0) && (glyph_code == '0))
        else $error("scroll record malformed");

    // While a record that is not the last one leaves, the character is still at work.
    assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && rec_ready && !last_record |-> !char_ready)
        else $error("new character accepted before its predecessor finished");

    // After a character is accepted, char_ready is low in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_ready |=> !char_ready)
        else $error("character accepted on consecutive cycles");

endmodule
